// File: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Opcodes, status codes and shared types of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  typedef logic [2:0] opcode_t;
  typedef logic [1:0] status_t;

  localparam opcode_t OP_APPEND = 3'd0;
  localparam opcode_t OP_BUILD  = 3'd1;
  localparam opcode_t OP_INSERT = 3'd2;
  localparam opcode_t OP_DELMAX = 3'd3;
  localparam opcode_t OP_READ   = 3'd4;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_EMPTY     = 2'd2;
  localparam status_t ST_BAD_INDEX = 2'd3;

  localparam int unsigned IN_KEY_BITS = 32;
  localparam int unsigned INDEX_BITS  = 7;
  localparam int unsigned COUNT_BITS  = 7;

endpackage

// File: rtl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Max-heap of signed keys held in one RAM, with a sift-down sequencer.
// ----------------------------------------------------------------------------
// Input beat: opcode, key and one-based index (append, build, insert,
// delete-max, read). Every input beat yields exactly one output beat with
// status, was_heap, the root key, the read key and the key count.
// One operation is in flight at a time: in_stall is high from the accept
// until the result is loaded into the output register. A finished result
// waits there while the next input beat is taken.
// Order of steps: append, full, empty, bad index and unused codes go from
// the accept straight to the done state; a good read waits for the RAM
// data first. The next beat is taken once the state is idle again. Build,
// insert and delete-max run the bottom-up heapify pass: a start step, a
// fetch of each node, a compare with the children (the right child is
// skipped when the left one stands alone), a write when a key comes to
// rest in a leaf, and the load of the result; delete-max first moves the
// last key up. The node fetch and the child reads each wait on the
// registered read of the single key RAM.
// Reset clears the key count and the control state; RAM contents are not
// cleared and are never read before being written.
// While out_stall is high with out_valid set, the output beat holds and a
// finished operation waits in S_DONE before loading the output register.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
  parameter int unsigned HEAP_DEPTH = 64,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mhpq_pkg::opcode_t                   in_opcode,
  input  logic signed [mhpq_pkg::IN_KEY_BITS-1:0] in_key_value,
  input  logic [mhpq_pkg::INDEX_BITS-1:0]     in_entry_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mhpq_pkg::status_t                   out_status,
  output logic                                out_was_heap,
  output logic signed [mhpq_pkg::IN_KEY_BITS-1:0] out_top_key,
  output logic signed [mhpq_pkg::IN_KEY_BITS-1:0] out_read_key,
  output logic [mhpq_pkg::COUNT_BITS-1:0]     out_key_count
);

  import mhpq_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IW = (CW > INDEX_BITS) ? CW : INDEX_BITS;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEL_W   = 4'd1;
  localparam logic [3:0] S_RD_W    = 4'd2;
  localparam logic [3:0] S_RB_INIT = 4'd3;
  localparam logic [3:0] S_NODE_RD = 4'd4;
  localparam logic [3:0] S_NODE_W  = 4'd5;
  localparam logic [3:0] S_SIFT    = 4'd6;
  localparam logic [3:0] S_LEFT_W  = 4'd7;
  localparam logic [3:0] S_RIGHT_W = 4'd8;
  localparam logic [3:0] S_CMP     = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  // control state
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  // working registers
  logic [CW-1:0]               node_r, node_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               child_r, child_nxt;
  logic signed [KEY_BITS-1:0]  held_r, held_nxt;
  logic signed [KEY_BITS-1:0]  left_r, left_nxt;
  logic signed [KEY_BITS-1:0]  ckey_r, ckey_nxt;
  logic signed [KEY_BITS-1:0]  top_r;
  status_t                     stat_r, stat_nxt;
  logic                        flag_r, flag_nxt;
  logic signed [KEY_BITS-1:0]  rdkey_r, rdkey_nxt;

  // output register payload
  status_t                        out_status_r;
  logic                           out_was_heap_r;
  logic signed [IN_KEY_BITS-1:0]  out_top_key_r;
  logic signed [IN_KEY_BITS-1:0]  out_read_key_r;
  logic [COUNT_BITS-1:0]          out_key_count_r;

  // RAM port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;

  logic signed [KEY_BITS-1:0] key_in;
  logic signed [KEY_BITS-1:0] rd_key;
  logic [IW-1:0]              idx_w;
  logic [IW-1:0]              cnt_w;
  logic [CW:0]                child2;
  logic [CW:0]                cnt_x;
  logic                       out_load;

  mhpq_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (HEAP_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign key_in   = KEY_BITS'(in_key_value);
  assign rd_key   = $signed(ram_rdata);
  assign idx_w    = IW'(in_entry_index);
  assign cnt_w    = IW'(count_r);
  assign child2   = {pos_r, 1'b0};
  assign cnt_x    = {1'b0, count_r};
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    node_nxt      = node_r;
    pos_nxt       = pos_r;
    child_nxt     = child_r;
    held_nxt      = held_r;
    left_nxt      = left_r;
    ckey_nxt      = ckey_r;
    stat_nxt      = stat_r;
    flag_nxt      = flag_r;
    rdkey_nxt     = rdkey_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          stat_nxt  = ST_OK;
          flag_nxt  = 1'b0;
          rdkey_nxt = '0;
          state_nxt = S_DONE;
          unique case (in_opcode)
            OP_APPEND, OP_INSERT: begin
              if (count_r == CW'(HEAP_DEPTH)) begin
                stat_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_r);
                ram_wdata = key_in;
                count_nxt = count_r + 1'b1;
                if (in_opcode == OP_INSERT) begin
                  state_nxt = S_RB_INIT;
                end
              end
            end
            OP_BUILD: begin
              state_nxt = S_RB_INIT;
            end
            OP_DELMAX: begin
              if (count_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else begin
                ram_raddr = AW'(count_r - 1'b1);
                state_nxt = S_DEL_W;
              end
            end
            OP_READ: begin
              if (idx_w == '0 || idx_w > cnt_w) begin
                stat_nxt = ST_BAD_INDEX;
              end else begin
                ram_raddr = AW'(idx_w - IW'(1));
                state_nxt = S_RD_W;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_DEL_W: begin
        // move the last key to the root and shrink
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        count_nxt = count_r - 1'b1;
        state_nxt = S_RB_INIT;
      end

      S_RD_W: begin
        rdkey_nxt = rd_key;
        state_nxt = S_DONE;
      end

      S_RB_INIT: begin
        flag_nxt = 1'b1;
        node_nxt = count_r >> 1;
        if ((count_r >> 1) == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NODE_RD;
        end
      end

      S_NODE_RD: begin
        ram_raddr = AW'(node_r - 1'b1);
        pos_nxt   = node_r;
        state_nxt = S_NODE_W;
      end

      S_NODE_W: begin
        held_nxt  = rd_key;
        state_nxt = S_SIFT;
      end

      S_SIFT: begin
        if (child2 <= cnt_x) begin
          ram_raddr = AW'(child2 - 1'b1);
          state_nxt = S_LEFT_W;
        end else begin
          // leaf reached: drop the held key here
          ram_we    = 1'b1;
          ram_waddr = AW'(pos_r - 1'b1);
          ram_wdata = held_r;
          node_nxt  = node_r - 1'b1;
          state_nxt = (node_r == CW'(1)) ? S_DONE : S_NODE_RD;
        end
      end

      S_LEFT_W: begin
        left_nxt = rd_key;
        if (child2 < cnt_x) begin
          ram_raddr = AW'(child2);
          state_nxt = S_RIGHT_W;
        end else begin
          child_nxt = CW'(child2);
          ckey_nxt  = rd_key;
          state_nxt = S_CMP;
        end
      end

      S_RIGHT_W: begin
        if (left_r < rd_key) begin
          child_nxt = CW'(child2 + 1'b1);
          ckey_nxt  = rd_key;
        end else begin
          child_nxt = CW'(child2);
          ckey_nxt  = left_r;
        end
        state_nxt = S_CMP;
      end

      S_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_r - 1'b1);
        if (held_r < ckey_r) begin
          // advance: larger child moves up
          ram_wdata = ckey_r;
          flag_nxt  = 1'b0;
          pos_nxt   = child_r;
          state_nxt = S_SIFT;
        end else begin
          ram_wdata = held_r;
          node_nxt  = node_r - 1'b1;
          state_nxt = (node_r == CW'(1)) ? S_DONE : S_NODE_RD;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    pos_r   <= pos_nxt;
    child_r <= child_nxt;
    held_r  <= held_nxt;
    left_r  <= left_nxt;
    ckey_r  <= ckey_nxt;
    stat_r  <= stat_nxt;
    flag_r  <= flag_nxt;
    rdkey_r <= rdkey_nxt;
    // shadow the root entry on every write to it
    if (ram_we && ram_waddr == '0) begin
      top_r <= $signed(ram_wdata);
    end
    if (out_load) begin
      out_status_r    <= stat_r;
      out_was_heap_r  <= flag_r;
      out_top_key_r   <= (count_r != '0) ? IN_KEY_BITS'(top_r) : '0;
      out_read_key_r  <= IN_KEY_BITS'(rdkey_r);
      out_key_count_r <= COUNT_BITS'(count_r);
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_was_heap  = out_was_heap_r;
  assign out_top_key   = out_top_key_r;
  assign out_read_key  = out_read_key_r;
  assign out_key_count = out_key_count_r;

endmodule

// File: rtl/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
